### src/zxm_pkg.sv
package zxm_pkg;

  localparam int KEY_ROW_COUNT = 8;
  localparam int KEY_IDX_W     = $clog2(KEY_ROW_COUNT);
  localparam int KEY_W         = 5;

  localparam logic [15:0] PORT_PAGING = 16'h7ffd;
  localparam logic [15:0] PORT_AY_SEL = 16'hfffd;
  localparam logic [15:0] PORT_AY_WR  = 16'hbffd;
  localparam logic [7:0]  PORT_ULA_LO = 8'hfe;
  localparam logic [15:0] SLOT_SIZE   = 16'h4000;
  localparam logic [7:0]  OPEN_BUS    = 8'hff;

  typedef enum logic [2:0] {
    OP_MEM_RD  = 3'd0,
    OP_MEM_WR  = 3'd1,
    OP_PORT_IN = 3'd2,
    OP_PORT_OUT = 3'd3,
    OP_SET_KEY = 3'd4,
    OP_RESET   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODEL_48K  = 2'd0,
    MODEL_128K = 2'd1,
    MODEL_PLUS3 = 2'd2,
    MODEL_ZX81 = 2'd3
  } model_t;

  typedef enum logic [1:0] {
    TGT_RAM  = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_NONE = 2'd2
  } target_t;

  typedef enum logic [1:0] {
    AY_NONE   = 2'd0,
    AY_SELECT = 2'd1,
    AY_WRITE  = 2'd2,
    AY_READ   = 2'd3
  } ay_action_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  data_in;
    logic        tape_ear;
  } item_t;

  typedef struct packed {
    logic [1:0]  mem_target;
    logic [16:0] mem_offset;
    logic        mem_write_enable;
    logic [7:0]  read_data;
    logic [1:0]  ay_action;
    logic [7:0]  ay_data;
    logic [2:0]  border_colour;
    logic        speaker_level;
    logic        mic_level;
    logic [2:0]  screen_page;
  } result_t;

  typedef struct packed {
    logic [2:0] paged_ram;
    logic       rom_select;
    logic       shadow_screen;
    logic       paging_locked;
    logic [2:0] border_reg;
    logic       speaker_reg;
    logic       mic_reg;
  } ula_state_t;

  typedef struct packed {
    logic                 we;
    logic [KEY_IDX_W-1:0] idx;
    logic [KEY_W-1:0]     val;
  } key_write_t;

  typedef logic [KEY_ROW_COUNT-1:0][KEY_W-1:0] key_rows_t;

endpackage

### src/zxm_decode.sv
module zxm_decode
  import zxm_pkg::*;
(
  input  item_t      item,
  input  model_t     model,
  input  ula_state_t st,
  input  key_rows_t  key_rows,
  output result_t    res,
  output ula_state_t st_next,
  output key_write_t kw
);

  logic             paged;
  logic [1:0]       slot;
  logic             wr;
  logic [KEY_W-1:0] acc;
  logic [2:0]       page;

  assign paged = (model == MODEL_128K) || (model == MODEL_PLUS3);
  assign slot  = item.address[15:14];
  assign wr    = (item.op == OP_MEM_WR);

  always_comb begin
    acc = '0;
    for (int i = 0; i < KEY_ROW_COUNT; i++) begin
      if (!item.address[8+i]) acc = acc | key_rows[i];
    end
  end

  always_comb begin
    case (slot)
      2'd1:    page = 3'd5;
      2'd2:    page = 3'd2;
      default: page = st.paged_ram;
    endcase
  end

  always_comb begin
    st_next = st;
    kw.we   = 1'b0;
    kw.idx  = item.address[KEY_IDX_W-1:0];
    kw.val  = item.data_in[KEY_W-1:0];
    res.mem_target       = TGT_NONE;
    res.mem_offset       = '0;
    res.mem_write_enable = 1'b0;
    res.read_data        = '0;
    res.ay_action        = AY_NONE;
    res.ay_data          = '0;

    case (item.op)
      OP_MEM_RD, OP_MEM_WR: begin
        if (model == MODEL_ZX81) begin
          if (item.address[15]) begin
            if (!wr) res.read_data = OPEN_BUS;
          end else begin
            // 8K windows mirrored in each of the two lower 16K slots
            res.mem_offset = {4'd0, item.address[12:0]};
            if (slot == 2'd0) begin
              res.mem_target = TGT_ROM;
            end else begin
              res.mem_target       = TGT_RAM;
              res.mem_write_enable = wr;
            end
          end
        end else if (slot == 2'd0) begin
          res.mem_target = TGT_ROM;
          res.mem_offset = {2'd0, paged & st.rom_select, item.address[13:0]};
        end else begin
          res.mem_target       = TGT_RAM;
          res.mem_write_enable = wr;
          if (paged) res.mem_offset = {page, item.address[13:0]};
          else       res.mem_offset = {1'b0, item.address - SLOT_SIZE};
        end
      end
      OP_PORT_IN: begin
        if (item.address == PORT_AY_SEL) begin
          res.ay_action = AY_READ;
        end else if (item.address[7:0] == PORT_ULA_LO) begin
          // pressed keys read low; bits 5 and 7 float high
          res.read_data = {1'b1, item.tape_ear, 1'b1, ~acc};
        end
      end
      OP_PORT_OUT: begin
        if (item.address[7:0] == PORT_ULA_LO) begin
          st_next.border_reg  = item.data_in[2:0];
          st_next.speaker_reg = !item.data_in[4];
          st_next.mic_reg     = !item.data_in[4] && !item.data_in[3];
        end else if (item.address == PORT_PAGING) begin
          if (paged && !st.paging_locked) begin
            st_next.paged_ram     = item.data_in[2:0];
            st_next.shadow_screen = item.data_in[3];
            st_next.rom_select    = item.data_in[4];
            st_next.paging_locked = item.data_in[5];
          end
        end else if (item.address == PORT_AY_WR) begin
          res.ay_action = AY_WRITE;
          res.ay_data   = item.data_in;
        end else if (item.address == PORT_AY_SEL) begin
          res.ay_action = AY_SELECT;
          res.ay_data   = item.data_in;
        end
      end
      OP_SET_KEY: kw.we = 1'b1;
      OP_RESET: begin
        st_next.paged_ram     = paged ? 3'd7 : 3'd0;
        st_next.rom_select    = 1'b0;
        st_next.shadow_screen = 1'b0;
        st_next.paging_locked = 1'b0;
      end
      default: ;
    endcase

    res.border_colour = st_next.border_reg;
    res.speaker_level = st_next.speaker_reg;
    res.mic_level     = st_next.mic_reg;
    res.screen_page   = !paged ? 3'd0 : (st_next.shadow_screen ? 3'd7 : 3'd5);
  end

endmodule

### src/zxm_state.sv
module zxm_state
  import zxm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       update,
  input  ula_state_t st_next,
  input  key_write_t kw,
  output ula_state_t st,
  output key_rows_t  key_rows
);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.paged_ram     <= 3'd0;
      st.rom_select    <= 1'b0;
      st.shadow_screen <= 1'b0;
      st.paging_locked <= 1'b0;
      st.border_reg    <= 3'd7;
      st.speaker_reg   <= 1'b0;
      st.mic_reg       <= 1'b0;
      key_rows         <= '0;
    end else if (update) begin
      st <= st_next;
      if (kw.we) key_rows[kw.idx] <= kw.val;
    end
  end

endmodule

### src/home_computer_memory_and_port_decoder.sv
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   tdata: address, data_in, tape_ear; tuser: op
// m_*      out  m_tvalid/m_tready   tdata: result fields; tuser: mem_target
// cfg_*    in   cfg_valid/cfg_ready machine_model
//
// One request a cycle unless the result side stalls; each request is held in the input register,
// then passes through the single decode stage into the result register.
// Reset empties the pipeline and resets the paging and ULA latches and the key rows.
// A stalled result holds the input register; once both are full s_tready drops.
// Model changes only when idle is a rule for the user; the block does not enforce it. cfg_ready is always high.
module home_computer_memory_and_port_decoder
  import zxm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address[15:0], data_in[23:16], tape_ear[24], zero
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // mem_offset[16:0], mem_write_enable[17], read_data[25:18],
                                 // ay_action[27:26], ay_data[35:28], border_colour[38:36],
                                 // speaker_level[39], mic_level[40], screen_page[43:41], zero
  output logic [1:0]  m_tuser,   // mem_target[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_res;
  model_t     model;
  logic       advance;
  ula_state_t st, st_next;
  key_rows_t  key_rows;
  key_write_t kw;
  result_t    res;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      model     <= MODEL_48K;
    end else begin
      if (cfg_valid) model <= model_t'(cfg_data);
      if (s_tready) in_valid <= s_tvalid;
      if (advance) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op       <= s_tuser;
      in_item.address  <= s_tdata[15:0];
      in_item.data_in  <= s_tdata[23:16];
      in_item.tape_ear <= s_tdata[24];
    end
    if (advance) out_res <= res;
  end

  zxm_decode u_decode (
    .item     (in_item),
    .model    (model),
    .st       (st),
    .key_rows (key_rows),
    .res      (res),
    .st_next  (st_next),
    .kw       (kw)
  );

  zxm_state u_state (
    .clk      (clk),
    .rst      (rst),
    .update   (advance),
    .st_next  (st_next),
    .kw       (kw),
    .st       (st),
    .key_rows (key_rows)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.mem_target;
  assign m_tdata  = {4'd0, out_res.screen_page, out_res.mic_level, out_res.speaker_level,
                     out_res.border_colour, out_res.ay_data, out_res.ay_action,
                     out_res.read_data, out_res.mem_write_enable, out_res.mem_offset};

endmodule

### sim/tb_home_computer_memory_and_port_decoder.sv
module tb_home_computer_memory_and_port_decoder;
  import zxm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class paging_decoder_model;
    model_t     machine_model;
    logic [2:0] paged_ram;
    logic       rom_select;
    logic       shadow_screen;
    logic       paging_locked;
    logic [4:0] key_rows [KEY_ROW_COUNT];
    logic [2:0] border_reg;
    logic       speaker_reg;
    logic       mic_reg;
    result_t    expected_results [$];
    int         mismatches;
    int         strays;
    int         checked;
    int         op_seen [6];

    function new();
      machine_model = MODEL_48K;
      paging_reset();
      foreach (key_rows[i]) key_rows[i] = '0;
      border_reg  = 3'd7;
      speaker_reg = 1'b0;
      mic_reg     = 1'b0;
      mismatches  = 0;
      strays      = 0;
      checked     = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function bit paged();
      return machine_model == MODEL_128K || machine_model == MODEL_PLUS3;
    endfunction

    function void paging_reset();
      paged_ram     = paged() ? 3'd7 : 3'd0;
      rom_select    = 1'b0;
      shadow_screen = 1'b0;
      paging_locked = 1'b0;
    endfunction

    // a model change leaves the paging latch alone until the next reset request
    function void set_model(model_t m);
      machine_model = m;
    endfunction

    function void note_request(item_t it);
      result_t     r;
      int unsigned a;
      int unsigned page;
      logic [4:0]  acc;
      logic        wr;
      r = '0;
      r.mem_target = TGT_NONE;
      a  = it.address;
      wr = (op_t'(it.op) == OP_MEM_WR);
      if (it.op < 6) op_seen[it.op]++;
      case (op_t'(it.op))
        OP_MEM_RD, OP_MEM_WR: begin
          if (machine_model == MODEL_ZX81) begin
            if (a > 32'h7fff) begin
              if (!wr) r.read_data = OPEN_BUS;
            end else begin
              r.mem_offset = 17'(a & 32'h1fff);
              if (a[15:14] == 2'd0) begin
                r.mem_target = TGT_ROM;
              end else begin
                r.mem_target       = TGT_RAM;
                r.mem_write_enable = wr;
              end
            end
          end else if (a[15:14] == 2'd0) begin
            r.mem_target = TGT_ROM;
            r.mem_offset = 17'((paged() ? rom_select * 16384 : 0) + (a & 32'h3fff));
          end else begin
            r.mem_target       = TGT_RAM;
            r.mem_write_enable = wr;
            if (paged()) begin
              page = (a[15:14] == 2'd1) ? 5 : (a[15:14] == 2'd2) ? 2 : paged_ram;
              r.mem_offset = 17'(page * 16384 + (a & 32'h3fff));
            end else begin
              r.mem_offset = 17'(a - 16384);
            end
          end
        end
        OP_PORT_IN: begin
          if (it.address == PORT_AY_SEL) begin
            r.ay_action = AY_READ;
          end else if (it.address[7:0] == PORT_ULA_LO) begin
            acc = '0;
            for (int i = 0; i < KEY_ROW_COUNT; i++)
              if (!it.address[8 + i]) acc |= key_rows[i];
            r.read_data = {1'b1, it.tape_ear, 1'b1, ~acc};
          end
        end
        OP_PORT_OUT: begin
          if (it.address[7:0] == PORT_ULA_LO) begin
            border_reg  = it.data_in[2:0];
            speaker_reg = !it.data_in[4];
            mic_reg     = it.data_in[4:3] == 2'b00;
          end else if (it.address == PORT_PAGING) begin
            if (paged() && !paging_locked) begin
              paged_ram     = it.data_in[2:0];
              rom_select    = it.data_in[4];
              shadow_screen = it.data_in[3];
              if (it.data_in[5]) paging_locked = 1'b1;
            end
          end else if (it.address == PORT_AY_WR) begin
            r.ay_action = AY_WRITE;
            r.ay_data   = it.data_in;
          end else if (it.address == PORT_AY_SEL) begin
            r.ay_action = AY_SELECT;
            r.ay_data   = it.data_in;
          end
        end
        OP_SET_KEY: key_rows[it.address[2:0]] = it.data_in[4:0];
        OP_RESET:   paging_reset();
        default: ;
      endcase
      r.border_colour = border_reg;
      r.speaker_level = speaker_reg;
      r.mic_level     = mic_reg;
      r.screen_page   = paged() ? (shadow_screen ? 3'd7 : 3'd5) : 3'd0;
      expected_results.push_back(r);
    endfunction

    function string describe(result_t r);
      return $sformatf("tgt=%0d off=%05h we=%b rd=%02h ay=%0d ayd=%02h bd=%0d spk=%b mic=%b scr=%0d",
                       r.mem_target, r.mem_offset, r.mem_write_enable, r.read_data,
                       r.ay_action, r.ay_data, r.border_colour, r.speaker_level,
                       r.mic_level, r.screen_page);
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (expected_results.size() == 0) begin
        strays++;
        $display("result with no request outstanding: %s", describe(act));
        return;
      end
      exp = expected_results.pop_front();
      checked++;
      if (exp.mem_target !== act.mem_target || exp.mem_offset !== act.mem_offset ||
          exp.mem_write_enable !== act.mem_write_enable ||
          exp.read_data !== act.read_data || exp.ay_action !== act.ay_action ||
          exp.ay_data !== act.ay_data || exp.border_colour !== act.border_colour ||
          exp.speaker_level !== act.speaker_level || exp.mic_level !== act.mic_level ||
          exp.screen_page !== act.screen_page) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d", checked);
          $display("  expected %s", describe(exp));
          $display("  actual   %s", describe(act));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  paging_decoder_model sb = new();
  int tx_idle_pct = 37;
  int rx_idle_pct = 71;
  int models_written = 0;

  always #5 clk = ~clk;

  home_computer_memory_and_port_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // result side: sample before the edge's updates land, then pick the next stall
  initial begin
    result_t act;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        act.mem_target       = m_tuser;
        act.mem_offset       = m_tdata[16:0];
        act.mem_write_enable = m_tdata[17];
        act.read_data        = m_tdata[25:18];
        act.ay_action        = m_tdata[27:26];
        act.ay_data          = m_tdata[35:28];
        act.border_colour    = m_tdata[38:36];
        act.speaker_level    = m_tdata[39];
        act.mic_level        = m_tdata[40];
        act.screen_page      = m_tdata[43:41];
        sb.check_result(act);
      end
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_req(input item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, it.tape_ear, it.data_in, it.address};
    s_tuser  <= it.op;
    do @(posedge clk); while (!s_tready);
    sb.note_request(it);
  endtask

  task automatic send_op(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                         input logic ear);
    item_t it;
    it.op       = op;
    it.address  = addr;
    it.data_in  = data;
    it.tape_ear = ear;
    send_req(it);
  endtask

  task automatic write_model(input model_t m);
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_model(m);
    models_written++;
  endtask

  function automatic item_t random_request();
    item_t it;
    int    r;
    int    k;
    it.address  = 16'($urandom_range(0, 65535));
    it.data_in  = 8'($urandom_range(0, 255));
    it.tape_ear = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 9);
    if (r < 22) begin
      it.op = OP_MEM_RD;
    end else if (r < 40) begin
      it.op = OP_MEM_WR;
    end else if (r < 58) begin
      it.op = OP_PORT_IN;
      if (k < 5) it.address[7:0] = PORT_ULA_LO;
      else if (k == 5) it.address = PORT_AY_SEL;
      else if (k == 6) it.address = PORT_AY_WR;
      else if (k == 7) it.address = PORT_PAGING;
    end else if (r < 80) begin
      it.op = OP_PORT_OUT;
      if (k < 3) begin
        it.address[7:0] = PORT_ULA_LO;
      end else if (k < 6) begin
        it.address = PORT_PAGING;
        // keep the lock bit rare so the latch stays writable most of the time
        if ($urandom_range(0, 99) < 80) it.data_in[5] = 1'b0;
      end else if (k == 6) begin
        it.address = PORT_AY_SEL;
      end else if (k == 7) begin
        it.address = PORT_AY_WR;
      end
    end else if (r < 94) begin
      it.op = OP_SET_KEY;
    end else begin
      it.op = OP_RESET;
    end
    return it;
  endfunction

  initial begin
    model_t batch_model [12];
    int     errors;
    batch_model = '{MODEL_48K, MODEL_128K, MODEL_PLUS3, MODEL_ZX81,
                    MODEL_PLUS3, MODEL_48K, MODEL_128K, MODEL_ZX81,
                    MODEL_128K, MODEL_ZX81, MODEL_PLUS3, MODEL_48K};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // paged model straight from reset: the bank still reads as page 0
    write_model(MODEL_128K);
    send_op(OP_MEM_RD,   16'hc000, 8'h00, 1'b0);
    send_op(OP_RESET,    16'h0000, 8'h00, 1'b0);
    send_op(OP_MEM_RD,   16'h0000, 8'h00, 1'b0);
    send_op(OP_MEM_WR,   16'h3fff, 8'hff, 1'b1);
    send_op(OP_PORT_OUT, PORT_PAGING, 8'h1b, 1'b0);
    send_op(OP_MEM_WR,   16'hffff, 8'h55, 1'b0);
    send_op(OP_MEM_RD,   16'h0001, 8'h00, 1'b0);
    send_op(OP_PORT_OUT, PORT_PAGING, 8'h20, 1'b0);
    send_op(OP_PORT_OUT, PORT_PAGING, 8'h1f, 1'b0);
    send_op(OP_MEM_RD,   16'h8000, 8'h00, 1'b0);
    send_op(OP_SET_KEY,  16'h0000, 8'hff, 1'b0);
    send_op(OP_SET_KEY,  16'hffff, 8'h15, 1'b0);
    send_op(OP_PORT_IN,  16'hfefe, 8'h00, 1'b1);
    send_op(OP_PORT_IN,  16'h7ffe, 8'h00, 1'b0);
    send_op(OP_PORT_IN,  16'hfffe, 8'h00, 1'b1);
    send_op(OP_PORT_IN,  16'h00fe, 8'h00, 1'b0);
    send_op(OP_PORT_IN,  PORT_AY_SEL, 8'h00, 1'b0);
    send_op(OP_PORT_IN,  PORT_AY_WR, 8'h00, 1'b0);
    send_op(OP_PORT_OUT, PORT_AY_SEL, 8'ha5, 1'b0);
    send_op(OP_PORT_OUT, PORT_AY_WR, 8'h5a, 1'b0);
    send_op(OP_PORT_OUT, 16'h12fe, 8'hff, 1'b0);
    send_op(OP_PORT_OUT, 16'h00fe, 8'h08, 1'b0);
    send_op(OP_PORT_OUT, 16'h00fe, 8'h00, 1'b0);
    // 8K mirrors and open bus above 0x7fff
    write_model(MODEL_ZX81);
    send_op(OP_MEM_RD,   16'h8000, 8'h00, 1'b0);
    send_op(OP_MEM_WR,   16'hffff, 8'h3c, 1'b0);
    send_op(OP_MEM_RD,   16'h6001, 8'h00, 1'b0);
    send_op(OP_MEM_WR,   16'h2000, 8'h3c, 1'b0);

    for (int b = 0; b < 12; b++) begin
      if (b == 4) begin
        tx_idle_pct = 71;
        rx_idle_pct = 37;
      end else if (b == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_model(batch_model[b]);
      repeat (100) send_req(random_request());
    end
    s_tvalid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    errors = sb.mismatches + sb.strays + sb.expected_results.size();
    $display("%0d requests over %0d model writes: %0d memory, %0d port, %0d key row, %0d paging reset",
             sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3] + sb.op_seen[4] +
             sb.op_seen[5], models_written, sb.op_seen[0] + sb.op_seen[1],
             sb.op_seen[2] + sb.op_seen[3], sb.op_seen[4], sb.op_seen[5]);
    $display("%0d results checked, %0d mismatched, %0d unexpected, %0d missing",
             sb.checked, sb.mismatches, sb.strays, sb.expected_results.size());
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### home_computer_memory_and_port_decoder.f
src/zxm_pkg.sv
src/zxm_decode.sv
src/zxm_state.sv
src/home_computer_memory_and_port_decoder.sv
sim/tb_home_computer_memory_and_port_decoder.sv
